// ----- hw/rtl/vhc_pkg.sv -----
// shared types and constants for the velocity heat color pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package vhc_pkg;

   // normalized speed t is Q1.12, t = 1.0 is T_ONE
   localparam int T_FRAC_BITS = 12;
   localparam int T_BITS      = T_FRAC_BITS + 1;
   // one hue sector spans 2^SECT_BITS steps of t
   localparam int SECT_BITS   = 10;
   localparam int SECT_SEL_BITS = T_BITS - SECT_BITS;

   // hue sectors, counted from red toward blue
   localparam logic [SECT_SEL_BITS-1:0] SECT_RED_RISE_GREEN  = 3'd0;
   localparam logic [SECT_SEL_BITS-1:0] SECT_FALL_RED        = 3'd1;
   localparam logic [SECT_SEL_BITS-1:0] SECT_RISE_BLUE       = 3'd2;
   localparam logic [SECT_SEL_BITS-1:0] SECT_FALL_GREEN      = 3'd3;
   localparam logic [SECT_SEL_BITS-1:0] SECT_BLUE_RISE_RED   = 3'd4;

   // configuration register indexes
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_SPEED = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_SPEED = 2'd1;

   // speed clamping flags carried beside the fraction divider
   typedef struct packed {
      logic lo;   // speed at or below min_speed
      logic hi;   // speed at or above max_speed, and above min_speed
   } sat_type;

endpackage

// ----- hw/rtl/velocity_heat_color.sv -----
// velocity heat color: velocity vector to thermal rgb color
// depends on vhc_pkg, vhc_isqrt, vhc_frac_div
//
// req_ channel carries one signed Q8.8 velocity vector per transfer;
// rsp_ channel returns one rgb color per vector, in order.
// csr_ channel writes min_speed (index 0) and max_speed (index 1);
// csr_ready is always high, other indexes are dropped. write only while idle.
// speed = floor sqrt of x^2+y^2+z^2, normalized between min and max to a
// Q1.12 fraction t, hue 240*(1-t) degrees, full saturation and value.
// throughput: one vector per cycle, sustained while rsp_tready stays high.
// pipeline from req transfer to rsp_tvalid: 3 magnitude/square/sum stages,
// VEL_BITS+1 square root stages, one clamp stage, 12 divider stages,
// one color stage, output register.
// reset: synchronous, clears the pipeline valid bits and loads
// min_speed 0 and max_speed 2560 (10.0).
// a stall on rsp_tready holds the whole pipeline once the skid register fills;
// the skid register catches the item in flight, so req_tready stays registered
// and nothing is lost or repeated.
`timescale 1ns / 1ps

module velocity_heat_color
   import vhc_pkg::*;
#(
   parameter int VEL_BITS     = 16,
   parameter int CHANNEL_BITS = 8,
   localparam int IN_DATA_BITS  = ((3 * VEL_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_BITS = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_DATA_BITS-1:0]  req_tdata,   // vel_x, vel_y, vel_z
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_DATA_BITS-1:0] rsp_tdata,   // red, green, blue
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [VEL_BITS-1:0]      csr_data
);

   localparam int SQ_BITS   = 2 * VEL_BITS;
   localparam int SUM_BITS  = 2 * VEL_BITS + 2;
   localparam int ROOT_BITS = VEL_BITS + 1;
   localparam int PROD_BITS = CHANNEL_BITS + SECT_BITS + 1;
   localparam logic [CHANNEL_BITS-1:0] CMAX = '1;
   localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC_BITS;

   logic en;

   logic [VEL_BITS-1:0] min_speed_ff;
   logic [VEL_BITS-1:0] max_speed_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_speed_ff <= '0;
         max_speed_ff <= VEL_BITS'(2560);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MIN_SPEED: min_speed_ff <= csr_data;
            CSR_MAX_SPEED: max_speed_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // magnitudes, squares and their sum
   logic signed [VEL_BITS-1:0] vel [3];
   logic [VEL_BITS-1:0] mag_in [3];
   logic [VEL_BITS-1:0] mag_ff [3];
   logic [SQ_BITS-1:0]  sq_ff  [3];
   logic [SUM_BITS-1:0] sum_ff;
   logic                mag_vld_ff;
   logic                sq_vld_ff;
   logic                sum_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel[i]    = req_tdata[i*VEL_BITS +: VEL_BITS];
         mag_in[i] = vel[i][VEL_BITS-1] ? VEL_BITS'(-vel[i]) : VEL_BITS'(vel[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_vld_ff <= 1'b0;
         sq_vld_ff  <= 1'b0;
         sum_vld_ff <= 1'b0;
      end else if (en) begin
         mag_vld_ff <= req_tvalid;
         sq_vld_ff  <= mag_vld_ff;
         sum_vld_ff <= sq_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= mag_in[i];
            sq_ff[i]  <= mag_ff[i] * mag_ff[i];
         end
         sum_ff <= SUM_BITS'(sq_ff[0]) + SUM_BITS'(sq_ff[1]) + SUM_BITS'(sq_ff[2]);
      end
   end

   // square root
   logic                 root_vld;
   logic [ROOT_BITS-1:0] root;

   vhc_isqrt #(
      .IN_BITS   (SUM_BITS),
      .ROOT_BITS (ROOT_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (sum_vld_ff),
      .in_val   (sum_ff),
      .out_vld  (root_vld),
      .out_root (root)
   );

   // clamp against the speed window
   logic                clamp_vld_ff;
   sat_type             sat_in;
   sat_type             sat_ff;
   logic [VEL_BITS-1:0] num_ff;
   logic [VEL_BITS-1:0] den_ff;

   always_comb begin
      sat_in.lo = root <= {1'b0, min_speed_ff};
      sat_in.hi = !sat_in.lo && (root >= {1'b0, max_speed_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_vld_ff <= 1'b0;
      end else if (en) begin
         clamp_vld_ff <= root_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat_ff <= sat_in;
         num_ff <= VEL_BITS'(root - {1'b0, min_speed_ff});
         den_ff <= max_speed_ff - min_speed_ff;
      end
   end

   // fraction of the window
   logic                   div_vld;
   logic [T_FRAC_BITS-1:0] quo;
   sat_type                div_sat;

   vhc_frac_div #(
      .DEN_BITS (VEL_BITS),
      .Q_BITS   (T_FRAC_BITS)
   ) u_frac_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (clamp_vld_ff),
      .in_num  (num_ff),
      .in_den  (den_ff),
      .in_sat  (sat_ff),
      .out_vld (div_vld),
      .out_quo (quo),
      .out_sat (div_sat)
   );

   // hue sector to rgb
   logic [T_BITS-1:0]        t;
   logic [T_BITS-1:0]        u;
   logic [SECT_SEL_BITS-1:0] sector;
   logic [SECT_BITS-1:0]     f;
   logic [SECT_BITS:0]       f_inv;
   logic [PROD_BITS-1:0]     rise_prod;
   logic [PROD_BITS-1:0]     fall_prod;
   logic [CHANNEL_BITS-1:0]  rise;
   logic [CHANNEL_BITS-1:0]  fall;
   logic [CHANNEL_BITS-1:0]  red_in;
   logic [CHANNEL_BITS-1:0]  green_in;
   logic [CHANNEL_BITS-1:0]  blue_in;

   always_comb begin
      if (div_sat.lo) begin
         t = '0;
      end else if (div_sat.hi) begin
         t = T_ONE;
      end else begin
         t = {1'b0, quo};
      end
      u      = T_ONE - t;
      sector = u[T_BITS-1:SECT_BITS];
      f      = u[SECT_BITS-1:0];
      f_inv  = (SECT_BITS+1)'(1 << SECT_BITS) - {1'b0, f};
      rise_prod = PROD_BITS'(CMAX) * PROD_BITS'(f)
                + PROD_BITS'(1 << (SECT_BITS - 1));
      fall_prod = PROD_BITS'(CMAX) * PROD_BITS'(f_inv)
                + PROD_BITS'(1 << (SECT_BITS - 1));
      rise = rise_prod[SECT_BITS +: CHANNEL_BITS];
      fall = fall_prod[SECT_BITS +: CHANNEL_BITS];
      case (sector)
         SECT_RED_RISE_GREEN: begin
            red_in = CMAX; green_in = rise; blue_in = '0;
         end
         SECT_FALL_RED: begin
            red_in = fall; green_in = CMAX; blue_in = '0;
         end
         SECT_RISE_BLUE: begin
            red_in = '0; green_in = CMAX; blue_in = rise;
         end
         SECT_FALL_GREEN: begin
            red_in = '0; green_in = fall; blue_in = CMAX;
         end
         SECT_BLUE_RISE_RED: begin
            red_in = rise; green_in = '0; blue_in = CMAX;
         end
         default: begin
            red_in = CMAX; green_in = '0; blue_in = fall;
         end
      endcase
   end

   logic                    col_vld_ff;
   logic [3*CHANNEL_BITS-1:0] col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_vld_ff <= 1'b0;
      end else if (en) begin
         col_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         col_ff <= {blue_in, green_in, red_in};
      end
   end

   // output register and skid
   logic                      out_vld_ff;
   logic [3*CHANNEL_BITS-1:0] out_ff;
   logic                      skid_vld_ff;
   logic [3*CHANNEL_BITS-1:0] skid_ff;
   logic                      out_free;

   assign en         = !skid_vld_ff;
   assign req_tready = !skid_vld_ff;
   assign out_free   = !out_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= col_vld_ff;
         end
      end else if (en && col_vld_ff) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_vld_ff ? skid_ff : col_ff;
      end else if (en) begin
         skid_ff <= col_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OUT_DATA_BITS'(out_ff);

   a_skid_needs_out : assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_drains : assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && rsp_tready) |=> !skid_vld_ff)
      else $error("skid did not drain after an output transfer");

   a_full_channel : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_ff[0 +: CHANNEL_BITS] == CMAX
                      || out_ff[CHANNEL_BITS +: CHANNEL_BITS] == CMAX
                      || out_ff[2*CHANNEL_BITS +: CHANNEL_BITS] == CMAX))
      else $error("color has no channel at full level");

   a_sat_exclusive : assert property (@(posedge clock) disable iff (reset)
      col_vld_ff |-> !($past(div_sat.lo) && $past(div_sat.hi)))
      else $error("speed clamped both low and high");

endmodule

// ----- hw/rtl/vhc_isqrt.sv -----
// pipelined integer square root, one root bit per register stage
// depends on vhc_pkg
`timescale 1ns / 1ps

module vhc_isqrt
   import vhc_pkg::*;
#(
   parameter int IN_BITS   = 34,
   parameter int ROOT_BITS = (IN_BITS + 1) / 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_vld,
   input  logic [IN_BITS-1:0]   in_val,
   output logic                 out_vld,
   output logic [ROOT_BITS-1:0] out_root
);

   logic                 vld_ff  [ROOT_BITS];
   logic [IN_BITS-1:0]   rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      localparam int I = ROOT_BITS - 1 - k;
      logic                 vld_prev;
      logic [IN_BITS-1:0]   rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [IN_BITS-1:0]   trial;
      logic [IN_BITS-1:0]   rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (k == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = in_val;
         assign root_prev = '0;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (root + 2^i)^2 - root^2 = root * 2^(i+1) + 2^(2i)
      always_comb begin
         trial = (IN_BITS'(root_prev) << (I + 1)) | (IN_BITS'(1) << (2 * I));
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (ROOT_BITS'(1) << I);
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_BITS-1];
   assign out_root = root_ff[ROOT_BITS-1];

endmodule

// ----- hw/rtl/vhc_frac_div.sv -----
// pipelined restoring divider for num / den with num below den,
// one quotient bit per register stage; depends on vhc_pkg
`timescale 1ns / 1ps

module vhc_frac_div
   import vhc_pkg::*;
#(
   parameter int DEN_BITS = 16,
   parameter int Q_BITS   = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  logic [DEN_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  sat_type             in_sat,
   output logic                out_vld,
   output logic [Q_BITS-1:0]   out_quo,
   output sat_type             out_sat
);

   logic                vld_ff [Q_BITS];
   logic [DEN_BITS-1:0] rem_ff [Q_BITS];
   logic [DEN_BITS-1:0] den_ff [Q_BITS];
   logic [Q_BITS-1:0]   quo_ff [Q_BITS];
   sat_type             sat_ff [Q_BITS];

   for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
      logic                vld_prev;
      logic [DEN_BITS-1:0] rem_prev;
      logic [DEN_BITS-1:0] den_prev;
      logic [Q_BITS-1:0]   quo_prev;
      sat_type             sat_prev;
      logic [DEN_BITS:0]   shifted;
      logic [DEN_BITS-1:0] rem_in;
      logic [Q_BITS-1:0]   quo_in;

      if (k == 0) begin : g_first
         assign vld_prev = in_vld;
         assign rem_prev = in_num;
         assign den_prev = in_den;
         assign quo_prev = '0;
         assign sat_prev = in_sat;
      end else begin : g_next
         assign vld_prev = vld_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign sat_prev = sat_ff[k-1];
      end

      always_comb begin
         shifted = {rem_prev, 1'b0};
         if (shifted >= {1'b0, den_prev}) begin
            rem_in = DEN_BITS'(shifted - {1'b0, den_prev});
            quo_in = {quo_prev[Q_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_BITS-1:0];
            quo_in = {quo_prev[Q_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_prev;
            quo_ff[k] <= quo_in;
            sat_ff[k] <= sat_prev;
         end
      end
   end

   assign out_vld = vld_ff[Q_BITS-1];
   assign out_quo = quo_ff[Q_BITS-1];
   assign out_sat = sat_ff[Q_BITS-1];

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for velocity_heat_color: drives velocity vectors and
// register writes, predicts each rgb color in the bench and checks every transfer
// depends on vhc_pkg and the velocity_heat_color rtl
`timescale 1ns / 1ps

module tb_top
   import vhc_pkg::*;
();

   localparam int PIPE_LATENCY = 16 + 19;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_VECTORS = 200;
   localparam int T_ONE = 1 << T_FRAC_BITS;
   localparam int SECT_SPAN = 1 << SECT_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // vel_x, vel_y, vel_z
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // red, green, blue
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   logic [15:0] min_cfg = 16'd0;
   logic [15:0] max_cfg = 16'd2560;
   bit          steady_flow = 1'b0;
   rgb_type     color_due[$];
   int          vectors_sent = 0;
   int          colors_checked = 0;
   int          csr_writes = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   velocity_heat_color dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d colors pending", cycle_count, color_due.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [16:0] component_magnitude(input logic [15:0] v);
      return v[15] ? 17'(17'h10000 - {1'b0, v}) : {1'b0, v};
   endfunction

   function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] b;
      rest = n;
      root = 0;
      b = 64'h1 << 62;
      while (b > rest)
         b >>= 2;
      while (b != 0) begin
         if (rest >= root + b) begin
            rest -= root + b;
            root = (root >> 1) + b;
         end else begin
            root >>= 1;
         end
         b >>= 2;
      end
      return root[31:0];
   endfunction

   function automatic logic [7:0] channel_level(input int unsigned num);
      return 8'((255 * num * 2 + SECT_SPAN) / (2 * SECT_SPAN));
   endfunction

   function automatic rgb_type heat_color(input logic [15:0] vx, vy, vz, lo, hi);
      logic [63:0]              ax, ay, az;
      logic [31:0]              speed;
      int unsigned              t, u, f;
      logic [7:0]               rise, fall;
      logic [SECT_SEL_BITS-1:0] sector;
      rgb_type                  c;
      ax = 64'(component_magnitude(vx));
      ay = 64'(component_magnitude(vy));
      az = 64'(component_magnitude(vz));
      speed = floor_sqrt(ax * ax + ay * ay + az * az);
      if (speed <= lo)
         t = 0;
      else if (speed >= hi)
         t = T_ONE;
      else
         t = ((speed - lo) * T_ONE) / (hi - lo);
      u = T_ONE - t;
      sector = SECT_SEL_BITS'(u / SECT_SPAN);
      f = u % SECT_SPAN;
      rise = channel_level(f);
      fall = channel_level(SECT_SPAN - f);
      case (sector)
         SECT_RED_RISE_GREEN: c = '{red: 8'hFF, green: rise,  blue: 8'h00};
         SECT_FALL_RED:       c = '{red: fall,  green: 8'hFF, blue: 8'h00};
         SECT_RISE_BLUE:      c = '{red: 8'h00, green: 8'hFF, blue: rise};
         SECT_FALL_GREEN:     c = '{red: 8'h00, green: fall,  blue: 8'hFF};
         SECT_BLUE_RISE_RED:  c = '{red: rise,  green: 8'h00, blue: 8'hFF};
         default:             c = '{red: 8'hFF, green: 8'h00, blue: fall};
      endcase
      return c;
   endfunction

   // half log-spread magnitudes so every hue band is reached, the rest extremes and full-range noise
   function automatic logic [15:0] rand_component();
      logic [15:0] mag;
      int          e;
      case ($urandom_range(5))
         0, 1: return 16'($urandom);
         2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         default: begin
            e = $urandom_range(15, 1);
            mag = 16'($urandom_range((1 << e) - 1, 0));
            return $urandom_range(1) ? 16'(-mag) : mag;
         end
      endcase
   endfunction

   always @(negedge clock)
      rsp_tready <= steady_flow || ($urandom_range(99) >= 38);

   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = '{red: rsp_tdata[7:0], green: rsp_tdata[15:8], blue: rsp_tdata[23:16]};
         if (color_due.size() == 0) begin
            $display("%0t unexpected color transfer: actual %h", $time, got);
            mismatches++;
         end else begin
            want = color_due.pop_front();
            colors_checked++;
            if (got.red !== want.red) begin
               $display("%0t red expected %0d actual %0d", $time, want.red, got.red);
               mismatches++;
            end
            if (got.green !== want.green) begin
               $display("%0t green expected %0d actual %0d", $time, want.green, got.green);
               mismatches++;
            end
            if (got.blue !== want.blue) begin
               $display("%0t blue expected %0d actual %0d", $time, want.blue, got.blue);
               mismatches++;
            end
         end
      end
   end

   task automatic send_velocity(input logic [15:0] vx, vy, vz);
      @(negedge clock);
      if (!steady_flow)
         while ($urandom_range(99) < 38) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      req_tvalid <= 1'b1;
      req_tdata  <= {vz, vy, vx};
      do @(posedge clock); while (req_tready !== 1'b1);
      color_due.push_back(heat_color(vx, vy, vz, min_cfg, max_cfg));
      vectors_sent++;
   endtask

   // drain the pipeline before touching the speed range
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (color_due.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx == CSR_MIN_SPEED)
         min_cfg = value;
      else if (idx == CSR_MAX_SPEED)
         max_cfg = value;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_speed_range(input logic [15:0] lo, hi);
      drain_pipeline();
      write_csr(CSR_MIN_SPEED, lo);
      write_csr(CSR_MAX_SPEED, hi);
   endtask

   // reset range 0..2560: zero, sector boundaries, extremes, mixed signs
   task automatic test_reset_range();
      send_velocity(16'h0000, 16'h0000, 16'h0000);
      send_velocity(16'd640, 16'h0000, 16'h0000);
      send_velocity(16'h0000, 16'd1280, 16'h0000);
      send_velocity(16'h0000, 16'h0000, 16'd1920);
      send_velocity(16'd2560, 16'h0000, 16'h0000);
      send_velocity(16'd300, 16'hFE70, 16'h0000);
      send_velocity(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_velocity(16'h8000, 16'h8000, 16'h8000);
      send_velocity(16'h7FFF, 16'h7FFF, 16'h7FFF);
   endtask

   // speed just below, at and just above each end of the range
   task automatic test_clamp_edges();
      set_speed_range(16'd256, 16'd1280);
      send_velocity(16'd255, 16'h0000, 16'h0000);
      send_velocity(16'h0000, 16'hFF00, 16'h0000);
      send_velocity(16'h0000, 16'h0000, 16'd257);
      send_velocity(16'd1279, 16'h0000, 16'h0000);
      send_velocity(16'hFB00, 16'h0000, 16'h0000);
      send_velocity(16'd1281, 16'h0000, 16'h0000);
   endtask

   // max not above min: blue up to min, red beyond
   task automatic test_collapsed_range();
      set_speed_range(16'd1000, 16'd1000);
      send_velocity(16'd1000, 16'h0000, 16'h0000);
      send_velocity(16'd1001, 16'h0000, 16'h0000);
      set_speed_range(16'd2000, 16'd500);
      send_velocity(16'd1500, 16'h0000, 16'h0000);
      send_velocity(16'h0000, 16'd2001, 16'h0000);
   endtask

   // writes to indexes with no register must leave the range alone
   task automatic test_unused_index();
      set_speed_range(16'd0, 16'd2048);
      write_csr(CSR_SPARE_A, 16'hFFFF);
      write_csr(CSR_SPARE_B, 16'h0001);
      send_velocity(16'd1024, 16'h0000, 16'h0000);
   endtask

   task automatic test_extreme_ranges();
      set_speed_range(16'd0, 16'd0);
      send_velocity(16'h0000, 16'h0000, 16'h0000);
      send_velocity(16'h0001, 16'h0000, 16'h0000);
      set_speed_range(16'hFFFF, 16'hFFFF);
      send_velocity(16'h8000, 16'h8000, 16'h8000);
      set_speed_range(16'd0, 16'hFFFF);
      send_velocity(16'h8000, 16'h8000, 16'h8000);
      send_velocity(16'h7FFF, 16'h0000, 16'h8000);
   endtask

   task automatic test_random_stream();
      int lo;
      int hi;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin lo = $urandom_range(512, 0);   hi = lo + $urandom_range(4096, 256); end
            1: begin lo = $urandom_range(8192, 0);  hi = lo + $urandom_range(32768, 1); end
            2: begin lo = $urandom_range(1024, 0);  hi = $urandom_range(16384, 1024); end
            3: begin lo = $urandom_range(65535, 0); hi = $urandom_range(65535, 0); end
            4: begin lo = $urandom_range(20000, 0); hi = lo + $urandom_range(40000, 1); end
            default: begin lo = 0; hi = $urandom_range(65535, 1); end
         endcase
         if (hi > 65535)
            hi = 65535;
         set_speed_range(16'(lo), 16'(hi));
         steady_flow = (p == 2);
         repeat (PHASE_VECTORS)
            send_velocity(rand_component(), rand_component(), rand_component());
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_range();
      test_clamp_edges();
      test_collapsed_range();
      test_unused_index();
      test_extreme_ranges();
      test_random_stream();
      drain_pipeline();
      $display("%0d vectors sent, %0d colors checked, %0d register writes", vectors_sent,
               colors_checked, csr_writes);
      $display("clamp edges, collapsed and extreme ranges, stalled and steady flow exercised");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/vhc_pkg.sv
hw/rtl/vhc_isqrt.sv
hw/rtl/vhc_frac_div.sv
hw/rtl/velocity_heat_color.sv
tb/tb_top.sv
